@@ rtl/fbda_pkg.sv @@
// Shared types, constants and the percent-drop helper for the free-block
// degradation alarm. No dependencies.
package fbda_pkg;

   localparam int TIME_W    = 32;
   localparam int SIZE_W    = 24;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = SIZE_W + PCT_W;

   localparam logic [TIME_W-1:0] BASELINE_INTERVAL_MS = TIME_W'(60000);
   localparam logic [TIME_W-1:0] WINDOW_MS            = TIME_W'(30000);
   localparam logic [TIME_W-1:0] SAMPLE_GAP_MS        = TIME_W'(1000);
   localparam logic [PCT_W-1:0]  WORSEN_PCT           = PCT_W'(5);
   localparam logic [PROD_W-1:0] PCT_SCALE            = PROD_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRITICAL_LEVEL,
      CSR_SEVERE_LEVEL,
      CSR_MIN_FREE_TOTAL,
      CSR_DEGRADE_PERCENT,
      CSR_SEVERE_WORSEN_PERCENT,
      CSR_PERSIST_MS,
      CSR_NORMAL_COOLDOWN_MS,
      CSR_SHORT_COOLDOWN_MS
   } csr_index_type;

   typedef enum logic [1:0] {
      CAUSE_NONE,
      CAUSE_CRITICAL,
      CAUSE_WORSENED,
      CAUSE_SEVERE
   } cause_type;

   typedef struct packed {
      logic [SIZE_W-1:0] critical_level;
      logic [SIZE_W-1:0] severe_level;
      logic [SIZE_W-1:0] min_free_total;
      logic [PCT_W-1:0]  degrade_percent;
      logic [PCT_W-1:0]  severe_worsen_percent;
      logic [SIZE_W-1:0] persist_ms;
      logic [SIZE_W-1:0] normal_cooldown_ms;
      logic [SIZE_W-1:0] short_cooldown_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      critical_level:        SIZE_W'(8192),
      severe_level:          SIZE_W'(16384),
      min_free_total:        SIZE_W'(32768),
      degrade_percent:       PCT_W'(30),
      severe_worsen_percent: PCT_W'(50),
      persist_ms:            SIZE_W'(10000),
      normal_cooldown_ms:    SIZE_W'(300000),
      short_cooldown_ms:     SIZE_W'(60000)
   };

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [SIZE_W-1:0] free_total;
      logic [SIZE_W-1:0] largest_free;
   } req_type;

   typedef struct packed {
      logic              dump_request;
      cause_type         dump_cause;
      logic              sample_pulse;
      logic              fragmented;
      logic              became_fragmented;
      logic              recovered;
      logic              active_window;
      logic [SIZE_W-1:0] baseline_now;
   } rsp_type;

   typedef struct packed {
      logic              started;
      logic [SIZE_W-1:0] baseline_block;
      logic [TIME_W-1:0] baseline_stamp;
      logic [TIME_W-1:0] dump_stamp;
      logic [SIZE_W-1:0] dumped_block;
      logic [TIME_W-1:0] frag_start;
      logic [SIZE_W-1:0] frag_start_block;
      logic              prev_fragmented;
      logic              window_open;
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] sample_stamp;
   } state_type;

   // (ref - cur) * 100 >= pct * ref, exact; false whenever cur > ref
   function automatic logic pct_drop(input logic [SIZE_W-1:0] ref_val,
                                     input logic [SIZE_W-1:0] cur_val,
                                     input logic [PCT_W-1:0]  pct);
      logic [SIZE_W-1:0] diff;
      logic [PROD_W-1:0] lhs;
      logic [PROD_W-1:0] rhs;
      diff = ref_val - cur_val;
      lhs  = PROD_W'(diff) * PCT_SCALE;
      rhs  = PROD_W'(pct) * PROD_W'(ref_val);
      return (cur_val <= ref_val) && (lhs >= rhs);
   endfunction

endpackage

@@ rtl/fbda_if.sv @@
// Valid/ready channel interfaces: request, response and register write.
// Depends on fbda_pkg for field widths.
interface fbda_req_if;
   logic                        valid;
   logic                        ready;
   logic [fbda_pkg::TIME_W-1:0] now_ms;
   logic [fbda_pkg::SIZE_W-1:0] free_total;
   logic [fbda_pkg::SIZE_W-1:0] largest_free;
   modport source (output valid, now_ms, free_total, largest_free, input ready);
   modport sink   (input valid, now_ms, free_total, largest_free, output ready);
endinterface

interface fbda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        dump_request;
   logic [1:0]                  dump_cause;
   logic                        sample_pulse;
   logic                        fragmented;
   logic                        became_fragmented;
   logic                        recovered;
   logic                        active_window;
   logic [fbda_pkg::SIZE_W-1:0] baseline_now;
   modport source (output valid, dump_request, dump_cause, sample_pulse, fragmented,
                   became_fragmented, recovered, active_window, baseline_now,
                   input ready);
   modport sink   (input valid, dump_request, dump_cause, sample_pulse, fragmented,
                   became_fragmented, recovered, active_window, baseline_now,
                   output ready);
endinterface

interface fbda_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fbda_pkg::CSR_IDX_W-1:0] index;
   logic [fbda_pkg::SIZE_W-1:0]    wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/fbda_csr.sv @@
// Configuration register file, written through the csr channel.
// Depends on fbda_pkg and fbda_csr_if.
module fbda_csr (
   input  logic              clock,
   input  logic              reset,
   fbda_csr_if.sink          csr_chan,
   output fbda_pkg::cfg_type cfg
);
   import fbda_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_CRITICAL_LEVEL:        cfg_in.critical_level        = csr_chan.wdata;
            CSR_SEVERE_LEVEL:          cfg_in.severe_level          = csr_chan.wdata;
            CSR_MIN_FREE_TOTAL:        cfg_in.min_free_total        = csr_chan.wdata;
            CSR_DEGRADE_PERCENT:       cfg_in.degrade_percent       = csr_chan.wdata[PCT_W-1:0];
            CSR_SEVERE_WORSEN_PERCENT: cfg_in.severe_worsen_percent = csr_chan.wdata[PCT_W-1:0];
            CSR_PERSIST_MS:            cfg_in.persist_ms            = csr_chan.wdata;
            CSR_NORMAL_COOLDOWN_MS:    cfg_in.normal_cooldown_ms    = csr_chan.wdata;
            CSR_SHORT_COOLDOWN_MS:     cfg_in.short_cooldown_ms     = csr_chan.wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/fbda_core.sv @@
// Single-pass tick evaluation: baseline, fragmentation, sampling window and
// dump decisions, plus the tracking state. Depends on fbda_pkg.
module fbda_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  fbda_pkg::req_type item,
   input  fbda_pkg::cfg_type cfg,
   output fbda_pkg::rsp_type rsp
);
   import fbda_pkg::*;

   state_type         st_ff;
   state_type         st_in;
   logic [SIZE_W-1:0] base0;
   logic [TIME_W-1:0] bstamp0;
   logic [TIME_W-1:0] since_dump;
   logic [TIME_W-1:0] short_cool;
   logic [TIME_W-1:0] cool;
   logic [SIZE_W-1:0] ref_blk;
   logic              crit;
   logic              frag;
   logic              worse;
   logic              severe;
   logic              expired;

   assign short_cool = TIME_W'(cfg.short_cooldown_ms);
   assign base0      = st_ff.started ? st_ff.baseline_block : item.largest_free;
   assign bstamp0    = st_ff.started ? st_ff.baseline_stamp : item.now_ms;
   assign since_dump = item.now_ms - st_ff.dump_stamp;
   assign crit       = (item.largest_free < cfg.critical_level) &&
                       ((since_dump >= short_cool) || (st_ff.dump_stamp == '0));
   assign frag       = (item.free_total >= cfg.min_free_total) && (base0 != '0) &&
                       pct_drop(base0, item.largest_free, cfg.degrade_percent);

   // worsening check against the last dump level, else the entry level
   assign ref_blk = (st_ff.dumped_block != '0) ? st_ff.dumped_block
                                               : st_ff.frag_start_block;
   always_comb begin
      worse  = 1'b0;
      severe = 1'b0;
      if ((ref_blk != '0) && (item.largest_free < ref_blk)) begin
         worse  = pct_drop(ref_blk, item.largest_free, WORSEN_PCT);
         severe = pct_drop(ref_blk, item.largest_free, cfg.severe_worsen_percent);
      end
      if (item.largest_free < cfg.severe_level || severe) begin
         cool = short_cool;
      end else begin
         cool = TIME_W'(cfg.normal_cooldown_ms);
      end
      expired = (since_dump >= cool) || (st_ff.dump_stamp == '0);
   end

   always_comb begin
      st_in                = st_ff;
      st_in.started        = 1'b1;
      st_in.baseline_block = base0;
      st_in.baseline_stamp = bstamp0;
      rsp                  = '0;
      rsp.dump_cause       = CAUSE_NONE;
      if (crit) begin
         rsp.dump_request   = 1'b1;
         rsp.dump_cause     = CAUSE_CRITICAL;
         rsp.fragmented     = st_ff.prev_fragmented;
         st_in.dump_stamp   = item.now_ms;
         st_in.dumped_block = item.largest_free;
      end else begin
         rsp.fragmented = frag;
         if (!frag && (item.now_ms - bstamp0 >= BASELINE_INTERVAL_MS)) begin
            if (item.largest_free > base0) begin
               st_in.baseline_block = item.largest_free;
            end
            st_in.baseline_stamp = item.now_ms;
         end
         if (st_ff.window_open && (item.now_ms - st_ff.window_start >= WINDOW_MS)) begin
            st_in.window_open  = 1'b0;
            st_in.window_start = '0;
            st_in.sample_stamp = '0;
         end
         if (st_in.window_open &&
             ((item.now_ms - st_in.sample_stamp >= SAMPLE_GAP_MS) ||
              (st_in.sample_stamp == '0))) begin
            rsp.sample_pulse   = 1'b1;
            st_in.sample_stamp = item.now_ms;
         end
         if (frag && !st_ff.prev_fragmented) begin
            rsp.became_fragmented  = 1'b1;
            st_in.frag_start       = item.now_ms;
            st_in.frag_start_block = item.largest_free;
            st_in.window_open      = 1'b1;
            st_in.window_start     = item.now_ms;
         end else if (!frag && st_ff.prev_fragmented) begin
            rsp.recovered          = 1'b1;
            st_in.window_open      = 1'b0;
            st_in.window_start     = '0;
            st_in.sample_stamp     = '0;
            st_in.frag_start       = '0;
            st_in.frag_start_block = '0;
            if (item.largest_free > st_in.baseline_block) begin
               st_in.baseline_block = item.largest_free;
            end
            st_in.baseline_stamp = item.now_ms;
         end else if (frag && (st_ff.frag_start != '0) &&
                      (item.now_ms - st_ff.frag_start >= TIME_W'(cfg.persist_ms))) begin
            if (worse && (expired || (severe && since_dump >= short_cool))) begin
               rsp.dump_request   = 1'b1;
               rsp.dump_cause     = severe ? CAUSE_SEVERE : CAUSE_WORSENED;
               st_in.dump_stamp   = item.now_ms;
               st_in.dumped_block = item.largest_free;
            end
         end
         st_in.prev_fragmented = frag;
      end
      rsp.active_window = st_in.window_open;
      rsp.baseline_now  = st_in.baseline_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

endmodule

@@ rtl/free_block_degradation_alarm.sv @@
// Free-block degradation alarm: one request per clock unless the response side
// stalls. A response is valid once the accepted request has passed the input
// register and then the response register; response back-pressure can hold it
// in the input register in between. The whole evaluation of a tick - the percent
// cross-products, the timer compares and the state update - is one combinational
// pass between those registers, so a new tick is taken every cycle while the
// response side keeps up. Register writes take effect the cycle after they
// are accepted and should only be made with no tick in flight.
// Depends on fbda_pkg, fbda_if, fbda_csr and fbda_core.
module free_block_degradation_alarm (
   input logic        clock,
   input logic        reset,
   fbda_req_if.sink   req_chan,
   fbda_rsp_if.source rsp_chan,
   fbda_csr_if.sink   csr_chan
);
   import fbda_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   cfg_type cfg;
   rsp_type core_rsp;
   logic    out_free;
   logic    advance;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;

   fbda_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   fbda_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff.now_ms       <= req_chan.now_ms;
         in_data_ff.free_total   <= req_chan.free_total;
         in_data_ff.largest_free <= req_chan.largest_free;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.dump_request      = out_data_ff.dump_request;
   assign rsp_chan.dump_cause        = out_data_ff.dump_cause;
   assign rsp_chan.sample_pulse      = out_data_ff.sample_pulse;
   assign rsp_chan.fragmented        = out_data_ff.fragmented;
   assign rsp_chan.became_fragmented = out_data_ff.became_fragmented;
   assign rsp_chan.recovered         = out_data_ff.recovered;
   assign rsp_chan.active_window     = out_data_ff.active_window;
   assign rsp_chan.baseline_now      = out_data_ff.baseline_now;

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated request did not reach the response register");

   a_cause_needs_dump: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.dump_request |-> out_data_ff.dump_cause == CAUSE_NONE)
      else $error("dump cause set without a dump");

   a_enter_opens_window: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.became_fragmented |->
         out_data_ff.fragmented && out_data_ff.active_window && !out_data_ff.recovered)
      else $error("entry into fragmented state without open window");

   a_recover_clears: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.recovered |->
         !out_data_ff.fragmented && !out_data_ff.active_window)
      else $error("recovery left fragmented state or window open");

endmodule

@@ tb/tb_free_block_degradation_alarm.sv @@
`timescale 1ns / 1ps
// Self-checking bench for free_block_degradation_alarm: a scripted tick table, then
// random tick sequences under several register settings, checked against a local model.
// Depends on fbda_pkg, fbda_if and the alarm RTL.
module tb_free_block_degradation_alarm;
   import fbda_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 4;

   localparam rsp_type RSP_IDLE  = '{1'b0, CAUSE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0};
   localparam rsp_type RSP_CRIT0 = '{1'b1, CAUSE_CRITICAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0};
   localparam cfg_type CFG_ZERO  = '0;
   localparam cfg_type CFG_TOP   = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd100, 7'd100,
                                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};

   typedef struct {
      logic [TIME_W-1:0] now_ms;
      logic [SIZE_W-1:0] free_total;
      logic [SIZE_W-1:0] largest_free;
      logic              known;
      rsp_type           want;
   } script_row_type;

   // first tick at zero block: critical dump, zero baseline; then worsening,
   // severe, cooldowns, recovery, wrap and a fragment start at time zero
   script_row_type script [21] = '{
      '{32'd1000,       24'd100000,  24'd0,       1'b1, RSP_CRIT0},
      '{32'd2000,       24'd100000,  24'd50000,   1'b1, RSP_IDLE},
      '{32'd62000,      24'd100000,  24'd50000,   1'b0, RSP_IDLE},
      '{32'd63000,      24'd100000,  24'd30000,   1'b0, RSP_IDLE},
      '{32'd63500,      24'd100000,  24'd30000,   1'b0, RSP_IDLE},
      '{32'd64000,      24'd100000,  24'd30000,   1'b0, RSP_IDLE},
      '{32'd400000,     24'd100000,  24'd28000,   1'b0, RSP_IDLE},
      '{32'd401000,     24'd100000,  24'd13000,   1'b0, RSP_IDLE},
      '{32'd460000,     24'd100000,  24'd13000,   1'b0, RSP_IDLE},
      '{32'd461000,     24'd100000,  24'd12000,   1'b0, RSP_IDLE},
      '{32'd470000,     24'hFFFFFF,  24'd0,       1'b0, RSP_IDLE},
      '{32'd520000,     24'hFFFFFF,  24'd0,       1'b0, RSP_IDLE},
      '{32'd530000,     24'hFFFFFF,  24'hFFFFFF,  1'b0, RSP_IDLE},
      '{32'd531000,     24'd0,       24'h010000,  1'b0, RSP_IDLE},
      '{32'hFFFFFF00,   24'hFFFFFF,  24'h100000,  1'b0, RSP_IDLE},
      '{32'h00000100,   24'hFFFFFF,  24'h100000,  1'b0, RSP_IDLE},
      '{32'h00003000,   24'hFFFFFF,  24'h0C0000,  1'b0, RSP_IDLE},
      '{32'h00004000,   24'hFFFFFF,  24'hFFFFFF,  1'b0, RSP_IDLE},
      '{32'h00000000,   24'hFFFFFF,  24'h100000,  1'b0, RSP_IDLE},
      '{32'd20000,      24'hFFFFFF,  24'h0F0000,  1'b0, RSP_IDLE},
      '{32'hFFFFFFFF,   24'd0,       24'd0,       1'b0, RSP_IDLE}
   };

   logic clock = 1'b0;
   logic reset;

   fbda_req_if req_chan ();
   fbda_rsp_if rsp_chan ();
   fbda_csr_if csr_chan ();

   free_block_degradation_alarm dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cfg_type           regs;
   state_type         alarm_st;
   rsp_type           alarms_due [$];
   int unsigned       fault_count = 0;
   int unsigned       alarm_count = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       tx_idle_pct = 0;
   int unsigned       rx_idle_pct = 0;
   int unsigned       holds_asked = 0;
   int unsigned       holds_done = 0;
   int unsigned       hold_left = 0;
   int unsigned       band = 0;
   logic [TIME_W-1:0] sim_now = '0;
   logic [SIZE_W-1:0] heap_peak = 24'h080000;

   function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] mark);
      return now - mark;
   endfunction

   // exact (base - cur) * 100 >= pct * base, signed
   function automatic logic drop_reaches(input logic [SIZE_W-1:0] base,
                                         input logic [SIZE_W-1:0] cur,
                                         input logic [PCT_W-1:0]  pct);
      longint lhs;
      longint rhs;
      lhs = (longint'(base) - longint'(cur)) * 100;
      rhs = longint'(pct) * longint'(base);
      return lhs >= rhs;
   endfunction

   function automatic rsp_type judge_tick(input req_type t);
      rsp_type           r;
      logic              frag;
      logic              worse;
      logic              severe;
      logic [SIZE_W-1:0] refb;
      logic [SIZE_W-1:0] cool;
      logic [TIME_W-1:0] gap;
      r      = RSP_IDLE;
      worse  = 1'b0;
      severe = 1'b0;
      if (!alarm_st.started) begin
         alarm_st.baseline_block = t.largest_free;
         alarm_st.baseline_stamp = t.now_ms;
         alarm_st.started        = 1'b1;
      end
      frag = alarm_st.prev_fragmented;
      if (t.largest_free < regs.critical_level &&
          (since(t.now_ms, alarm_st.dump_stamp) >= regs.short_cooldown_ms ||
           alarm_st.dump_stamp == 0)) begin
         r.dump_request        = 1'b1;
         r.dump_cause          = CAUSE_CRITICAL;
         alarm_st.dump_stamp   = t.now_ms;
         alarm_st.dumped_block = t.largest_free;
      end else begin
         frag = t.free_total >= regs.min_free_total && alarm_st.baseline_block != 0 &&
                drop_reaches(alarm_st.baseline_block, t.largest_free, regs.degrade_percent);
         if (!frag && since(t.now_ms, alarm_st.baseline_stamp) >= BASELINE_INTERVAL_MS) begin
            if (t.largest_free > alarm_st.baseline_block)
               alarm_st.baseline_block = t.largest_free;
            alarm_st.baseline_stamp = t.now_ms;
         end
         if (alarm_st.window_open && since(t.now_ms, alarm_st.window_start) >= WINDOW_MS) begin
            alarm_st.window_open  = 1'b0;
            alarm_st.window_start = '0;
            alarm_st.sample_stamp = '0;
         end
         if (alarm_st.window_open &&
             (since(t.now_ms, alarm_st.sample_stamp) >= SAMPLE_GAP_MS ||
              alarm_st.sample_stamp == 0)) begin
            r.sample_pulse        = 1'b1;
            alarm_st.sample_stamp = t.now_ms;
         end
         if (frag && !alarm_st.prev_fragmented) begin
            r.became_fragmented       = 1'b1;
            alarm_st.frag_start       = t.now_ms;
            alarm_st.frag_start_block = t.largest_free;
            alarm_st.window_open      = 1'b1;
            alarm_st.window_start     = t.now_ms;
         end else if (!frag && alarm_st.prev_fragmented) begin
            r.recovered               = 1'b1;
            alarm_st.window_open      = 1'b0;
            alarm_st.window_start     = '0;
            alarm_st.sample_stamp     = '0;
            alarm_st.frag_start       = '0;
            alarm_st.frag_start_block = '0;
            if (t.largest_free > alarm_st.baseline_block)
               alarm_st.baseline_block = t.largest_free;
            alarm_st.baseline_stamp = t.now_ms;
         end else if (frag && alarm_st.frag_start != 0 &&
                      since(t.now_ms, alarm_st.frag_start) >= regs.persist_ms) begin
            refb = (alarm_st.dumped_block != 0) ? alarm_st.dumped_block
                                                : alarm_st.frag_start_block;
            if (refb != 0 && t.largest_free < refb) begin
               worse  = drop_reaches(refb, t.largest_free, WORSEN_PCT);
               severe = drop_reaches(refb, t.largest_free, regs.severe_worsen_percent);
            end
            cool = severe ? regs.short_cooldown_ms : regs.normal_cooldown_ms;
            if (t.largest_free < regs.severe_level)
               cool = regs.short_cooldown_ms;
            gap = since(t.now_ms, alarm_st.dump_stamp);
            if (worse && (gap >= cool || alarm_st.dump_stamp == 0 ||
                          (severe && gap >= regs.short_cooldown_ms))) begin
               r.dump_request        = 1'b1;
               r.dump_cause          = severe ? CAUSE_SEVERE : CAUSE_WORSENED;
               alarm_st.dump_stamp   = t.now_ms;
               alarm_st.dumped_block = t.largest_free;
            end
         end
         alarm_st.prev_fragmented = frag;
      end
      r.fragmented    = frag;
      r.active_window = alarm_st.window_open;
      r.baseline_now  = alarm_st.baseline_block;
      return r;
   endfunction

   // mostly a drifting heap with sticky health bands; a few fully random requests
   function automatic req_type next_tick();
      req_type         t;
      longint unsigned blk;
      longint unsigned spare;
      int unsigned     frac;
      int unsigned     pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         t.now_ms       = $urandom;
         t.free_total   = SIZE_W'($urandom);
         t.largest_free = SIZE_W'($urandom);
         sim_now        = t.now_ms;
         return t;
      end
      if (pick < 8)
         heap_peak = SIZE_W'($urandom_range(24'hFFFFFF, 24'h000400));
      if ($urandom_range(3) == 0)
         band = $urandom_range(3);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: sim_now += $urandom_range(1500);
         5, 6, 7:       sim_now += $urandom_range(20000);
         8:             sim_now += $urandom_range(120000);
         default:       sim_now += $urandom_range(400000);
      endcase
      case (band)
         0:       frac = $urandom_range(1000, 880);
         1:       frac = $urandom_range(880, 450);
         2:       frac = $urandom_range(450, 0);
         default: frac = $urandom_range(1100, 950);
      endcase
      blk = (longint'(heap_peak) * frac) / 1000;
      if (blk > 24'hFFFFFF)
         blk = 24'hFFFFFF;
      if ($urandom_range(9) == 0) begin
         spare = $urandom_range(32'(blk));
      end else begin
         spare = blk + $urandom_range(heap_peak);
         if (spare > 24'hFFFFFF)
            spare = 24'hFFFFFF;
      end
      t.now_ms       = sim_now;
      t.free_total   = SIZE_W'(spare);
      t.largest_free = SIZE_W'(blk);
      return t;
   endfunction

   function automatic cfg_type roll_regs(input int unsigned pct_top);
      cfg_type c;
      c.critical_level        = SIZE_W'($urandom_range(heap_peak >> 3));
      c.severe_level          = SIZE_W'($urandom_range(heap_peak >> 1));
      c.min_free_total        = SIZE_W'($urandom_range(heap_peak >> 1));
      c.degrade_percent       = PCT_W'($urandom_range(pct_top));
      c.severe_worsen_percent = PCT_W'($urandom_range(pct_top));
      c.persist_ms            = SIZE_W'($urandom_range(30000));
      c.normal_cooldown_ms    = SIZE_W'($urandom_range(200000));
      c.short_cooldown_ms     = SIZE_W'($urandom_range(60000));
      return c;
   endfunction

   task automatic flag_error(input string what);
      if (fault_count < 100)
         $display("ERROR: %s", what);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic [SIZE_W-1:0] got,
                              input logic [SIZE_W-1:0] want);
      if (got !== want)
         flag_error($sformatf("response %0d %s: got %0h, expected %0h",
                              alarm_count, name, got, want));
   endtask

   task automatic offer_tick(input req_type t, input logic known, input rsp_type want);
      rsp_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.now_ms       <= t.now_ms;
      req_chan.free_total   <= t.free_total;
      req_chan.largest_free <= t.largest_free;
      do @(posedge clock); while (!req_chan.ready);
      r = judge_tick(t);
      alarms_due.push_back(known ? want : r);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (alarms_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_regs(input cfg_type c);
      csr_index_type     idx;
      logic [SIZE_W-1:0] val;
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_CRITICAL_LEVEL:        val = c.critical_level;
            CSR_SEVERE_LEVEL:          val = c.severe_level;
            CSR_MIN_FREE_TOTAL:        val = c.min_free_total;
            CSR_DEGRADE_PERCENT:       val = SIZE_W'(c.degrade_percent);
            CSR_SEVERE_WORSEN_PERCENT: val = SIZE_W'(c.severe_worsen_percent);
            CSR_PERSIST_MS:            val = c.persist_ms;
            CSR_NORMAL_COOLDOWN_MS:    val = c.normal_cooldown_ms;
            default:                   val = c.short_cooldown_ms;
         endcase
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx;
         csr_chan.wdata <= val;
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
      regs = c;
   endtask

   // response side: random backpressure, plus long holds on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done     <= holds_done + 1;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("free_block_degradation_alarm: mismatch");
            $finish;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (alarms_due.size() == 0) begin
               flag_error($sformatf("response %0d with no request pending", alarm_count));
            end else begin
               want = alarms_due.pop_front();
               check_field("dump_request", SIZE_W'(rsp_chan.dump_request),
                           SIZE_W'(want.dump_request));
               check_field("dump_cause", SIZE_W'(rsp_chan.dump_cause),
                           SIZE_W'(want.dump_cause));
               check_field("sample_pulse", SIZE_W'(rsp_chan.sample_pulse),
                           SIZE_W'(want.sample_pulse));
               check_field("fragmented", SIZE_W'(rsp_chan.fragmented),
                           SIZE_W'(want.fragmented));
               check_field("became_fragmented", SIZE_W'(rsp_chan.became_fragmented),
                           SIZE_W'(want.became_fragmented));
               check_field("recovered", SIZE_W'(rsp_chan.recovered),
                           SIZE_W'(want.recovered));
               check_field("active_window", SIZE_W'(rsp_chan.active_window),
                           SIZE_W'(want.active_window));
               check_field("baseline_now", rsp_chan.baseline_now, want.baseline_now);
            end
            alarm_count++;
         end
      end
   end

   initial begin
      cfg_type     plan;
      int unsigned quota;
      req_type     t;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.now_ms       <= '0;
      req_chan.free_total   <= '0;
      req_chan.largest_free <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= CSR_CRITICAL_LEVEL;
      csr_chan.wdata        <= '0;
      regs                  = CFG_RESET;
      alarm_st              = '0;
      tx_idle_pct           = 25;
      rx_idle_pct           = 60;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         t = '{script[i].now_ms, script[i].free_total, script[i].largest_free};
         offer_tick(t, script[i].known, script[i].want);
      end
      for (int n = 0; n < 120; n++)
         offer_tick(next_tick(), 1'b0, RSP_IDLE);

      for (int p = 1; p <= 6; p++) begin
         settle();
         case (p)
            1:       plan = CFG_ZERO;
            2:       plan = CFG_TOP;
            4:       plan = roll_regs(127);
            default: plan = roll_regs(100);
         endcase
         load_regs(plan);
         if (p == 1) begin
            tx_idle_pct = 25;
            rx_idle_pct = 60;
         end else if (p <= 3) begin
            tx_idle_pct = 60;
            rx_idle_pct = 25;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         quota = (p <= 2) ? 100 : 140;
         for (int n = 0; n < quota; n++) begin
            if ((p == 1 || p == 5) && n == 40)
               holds_asked++;
            if (p == 3 && n == 70)
               settle();
            offer_tick(next_tick(), 1'b0, RSP_IDLE);
         end
      end

      settle();
      if (fault_count == 0)
         $display("free_block_degradation_alarm: match");
      else
         $display("free_block_degradation_alarm: mismatch");
      $finish;
   end

endmodule
